// ----- hw/rtl/tcpkq_pkg.sv -----
// Package of the two-class priority key queue.
// Holds the sizes, the operation codes and the entry layout; no dependencies.
package tcpkq_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_KEY     = 4095;
    localparam int KEY_W       = 12;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = KEY_W + 1;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;
    localparam logic [1:0] OP_LOOKUP = 2'd3;

    typedef struct packed {
        logic             urgent;
        logic [KEY_W-1:0] key;
    } t_entry;
endpackage

// ----- hw/rtl/two_class_priority_key_queue.sv -----
// Top level of the two-class priority key queue.
// Depends on tcpkq_pkg and tcpkq_ram.
//
// The queue holds up to 16 unique keys in one RAM, in queue order with slot 0
// at the head; urgent keys sit ahead of normal ones. Each transaction is
// handled alone: a scan reads every occupied slot, then an add, remove or pop
// moves the trailing entries one slot per cycle through the RAM port, and an
// add writes its entry after the move. One result follows every input
// transaction; the next input is taken while a result waits.
module two_class_priority_key_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // key [11:0], entry_class [12], urgent [13], zero [15:14]
    input  logic [15:0] i_s_tdata,
    // operation [1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // status [0], found [1], popped_key [13:2], count [18:14], zero [23:19]
    output logic [23:0] o_m_tdata
);
    localparam int AW = tcpkq_pkg::ADDR_W;
    localparam int CW = tcpkq_pkg::CNT_W;
    localparam int KW = tcpkq_pkg::KEY_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_INS   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    localparam logic [CW-1:0] DEPTH_C = CW'(tcpkq_pkg::QUEUE_DEPTH);
    localparam logic [16:0]   MAXK_C  = 17'(tcpkq_pkg::MAX_KEY);

    logic [2:0]    r_state, n_state;
    logic          r_qclass;
    logic [CW-1:0] r_occ, n_occ;
    logic [1:0]    r_op;
    logic [KW-1:0] r_key;
    logic          r_cls, r_urg;
    logic [CW-1:0] r_ra, n_ra;
    logic [CW-1:0] r_raddr;
    logic          r_rv;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_up, n_up;
    logic [CW-1:0] r_pos, n_pos;
    logic          r_hit, n_hit;
    logic [CW-1:0] r_hpos, n_hpos;
    logic          r_nu, n_nu;
    logic [CW-1:0] r_nupos, n_nupos;
    logic [KW-1:0] r_head, n_head;
    logic          r_fail, n_fail;
    logic          r_found, n_found;
    logic [KW-1:0] r_pkey, n_pkey;
    logic          r_ov;
    logic [23:0]   r_odata;

    logic          ren, wen;
    logic [CW-1:0] raddr, waddr;
    tcpkq_pkg::t_entry wdata, rdata;
    logic          key_ok;
    logic          accept;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign key_ok     = (17'(r_key) <= MAXK_C);

    tcpkq_ram #(
        .WIDTH(tcpkq_pkg::ENTRY_W),
        .DEPTH(tcpkq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (wen),
        .i_waddr(waddr[AW-1:0]),
        .i_wdata(wdata),
        .i_re   (ren),
        .i_raddr(raddr[AW-1:0]),
        .o_rdata(rdata)
    );

    always_comb begin
        n_state = r_state;
        n_occ   = r_occ;
        n_ra    = r_ra;
        n_cnt   = r_cnt;
        n_up    = r_up;
        n_pos   = r_pos;
        n_hit   = r_hit;
        n_hpos  = r_hpos;
        n_nu    = r_nu;
        n_nupos = r_nupos;
        n_head  = r_head;
        n_fail  = r_fail;
        n_found = r_found;
        n_pkey  = r_pkey;
        ren     = 1'b0;
        raddr   = r_ra;
        wen     = 1'b0;
        waddr   = '0;
        wdata   = rdata;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN;
                    n_ra    = '0;
                    n_hit   = 1'b0;
                    n_nu    = 1'b0;
                    n_head  = '0;
                end
            end
            ST_SCAN: begin
                if (r_ra < r_occ) begin
                    ren  = 1'b1;
                    n_ra = r_ra + 1'b1;
                end
                if (r_rv) begin
                    if (rdata.key == r_key && !r_hit) begin
                        n_hit  = 1'b1;
                        n_hpos = r_raddr;
                    end
                    if (!rdata.urgent && !r_nu) begin
                        n_nu    = 1'b1;
                        n_nupos = r_raddr;
                    end
                    if (r_raddr == '0) begin
                        n_head = rdata.key;
                    end
                end
                if (r_ra >= r_occ && !r_rv) begin
                    n_fail  = 1'b1;
                    n_found = 1'b0;
                    n_pkey  = '0;
                    n_state = ST_FIN;
                    case (r_op)
                        tcpkq_pkg::OP_ADD: begin
                            if (r_cls == r_qclass && !(r_hit && key_ok)
                                    && r_occ != DEPTH_C) begin
                                n_fail  = 1'b0;
                                n_up    = 1'b1;
                                n_pos   = (r_urg && r_nu) ? r_nupos : r_occ;
                                n_cnt   = r_occ - n_pos;
                                n_ra    = r_occ - 1'b1;
                                n_state = ST_SHIFT;
                            end
                        end
                        tcpkq_pkg::OP_REMOVE: begin
                            if (r_hit && key_ok) begin
                                n_fail  = 1'b0;
                                n_up    = 1'b0;
                                n_pos   = r_hpos;
                                n_cnt   = r_occ - 1'b1 - r_hpos;
                                n_ra    = r_hpos + 1'b1;
                                n_state = ST_SHIFT;
                            end
                        end
                        tcpkq_pkg::OP_POP: begin
                            if (r_occ != '0) begin
                                n_fail  = 1'b0;
                                n_pkey  = r_head;
                                n_up    = 1'b0;
                                n_pos   = '0;
                                n_cnt   = r_occ - 1'b1;
                                n_ra    = CW'(1);
                                n_state = ST_SHIFT;
                            end
                        end
                        default: begin
                            n_fail  = 1'b0;
                            n_found = r_hit && key_ok;
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                if (r_cnt != '0) begin
                    ren   = 1'b1;
                    n_cnt = r_cnt - 1'b1;
                    n_ra  = r_up ? r_ra - 1'b1 : r_ra + 1'b1;
                end
                if (r_rv) begin
                    wen   = 1'b1;
                    waddr = r_up ? r_raddr + 1'b1 : r_raddr - 1'b1;
                end
                if (r_cnt == '0 && !r_rv) begin
                    if (r_up) begin
                        n_state = ST_INS;
                    end else begin
                        n_occ   = r_occ - 1'b1;
                        n_state = ST_FIN;
                    end
                end
            end
            ST_INS: begin
                wen          = 1'b1;
                waddr        = r_pos;
                wdata.urgent = r_urg;
                wdata.key    = r_key;
                n_occ        = r_occ + 1'b1;
                n_state      = ST_FIN;
            end
            ST_FIN: begin
                if (!r_ov || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_qclass <= 1'b0;
            r_occ    <= '0;
            r_rv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_rv    <= ren;
            if (i_cfg_we) begin
                r_qclass <= i_cfg_wdata;
            end
            if (r_state == ST_FIN && (!r_ov || i_m_tready)) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra    <= n_ra;
        r_raddr <= raddr;
        r_cnt   <= n_cnt;
        r_up    <= n_up;
        r_pos   <= n_pos;
        r_hit   <= n_hit;
        r_hpos  <= n_hpos;
        r_nu    <= n_nu;
        r_nupos <= n_nupos;
        r_head  <= n_head;
        r_fail  <= n_fail;
        r_found <= n_found;
        r_pkey  <= n_pkey;
        if (accept) begin
            r_op  <= i_s_tuser;
            r_key <= i_s_tdata[11:0];
            r_cls <= i_s_tdata[12];
            r_urg <= i_s_tdata[13];
        end
        if (r_state == ST_FIN && (!r_ov || i_m_tready)) begin
            r_odata <= {5'd0, r_occ, r_pkey, r_found, r_fail};
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= DEPTH_C)
        else $error("occupancy above queue depth");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready)
        else $error("input taken while an operation is in progress");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> (r_occ == $past(r_occ)))
        else $error("occupancy changed while idle");
endmodule

// ----- hw/rtl/tcpkq_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tcpkq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- tb/sv/two_class_priority_key_queue_tb.sv -----
// Self-checking testbench of the two-class priority key queue.
// Depends on tcpkq_pkg and the two_class_priority_key_queue top level.
// A directed table and random operations are checked against a queue predictor.
`timescale 1ns / 1ps

module two_class_priority_key_queue_tb;
    typedef struct packed {
        logic [4:0]  count;
        logic [11:0] popped_key;
        logic        found;
        logic        status;
    } t_result;

    typedef struct {
        logic [1:0]  op;
        logic [11:0] key;
        logic        cls;
        logic        urg;
        logic        chk;
        t_result     res;
    } t_row;

    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1830;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;

    two_class_priority_key_queue u_top (.*);

    // Predictor state.
    logic [11:0] q_keys[$];
    logic        q_urg[$];
    logic        q_class;
    t_result     pending_results[$];

    int  mismatches;
    int  row_errors;
    int  idle_cycles;
    bit  timed_out;
    bit  quiet_phase;
    bit  send_done;
    t_row rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int slot_of(logic [11:0] k);
        if (k > tcpkq_pkg::MAX_KEY) return -1;
        foreach (q_keys[i]) if (q_keys[i] == k) return i;
        return -1;
    endfunction

    function automatic t_result queue_step(logic [1:0] op, logic [11:0] k, logic cls,
                                           logic urg);
        t_result r;
        int s;
        int pos;
        r = '0;
        r.status = 1'b1;
        case (op)
            tcpkq_pkg::OP_ADD: begin
                if (cls == q_class && slot_of(k) < 0 &&
                    q_keys.size() < tcpkq_pkg::QUEUE_DEPTH) begin
                    pos = q_keys.size();
                    if (urg) begin
                        pos = 0;
                        while (pos < q_keys.size() && q_urg[pos]) pos++;
                    end
                    q_keys.insert(pos, k);
                    q_urg.insert(pos, urg);
                    r.status = 1'b0;
                end
            end
            tcpkq_pkg::OP_REMOVE: begin
                s = slot_of(k);
                if (s >= 0) begin
                    q_keys.delete(s);
                    q_urg.delete(s);
                    r.status = 1'b0;
                end
            end
            tcpkq_pkg::OP_POP: begin
                if (q_keys.size() > 0) begin
                    r.popped_key = q_keys.pop_front();
                    void'(q_urg.pop_front());
                    r.status = 1'b0;
                end
            end
            default: begin
                r.found = slot_of(k) >= 0;
                r.status = 1'b0;
            end
        endcase
        r.count = 5'(q_keys.size());
        return r;
    endfunction

    function automatic bit idle_now();
        return !quiet_phase && $urandom_range(99) < 20;
    endfunction

    task automatic send_op(logic [1:0] op, logic [11:0] k, logic cls, logic urg,
                           logic chk, t_result want);
        t_result r;
        if (idle_now()) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
            while (idle_now()) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {2'b00, urg, cls, k};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        r = queue_step(op, k, cls, urg);
        if (chk && r != want) begin
            row_errors++;
            if (mismatches + row_errors <= 10)
                $display("table row op %0d key %0d: typed %h, predictor %h",
                         op, k, want, r);
        end
        pending_results.push_back(r);
        @(negedge i_clk);
    endtask

    task automatic drain_and_config(logic cls);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cls;
        q_class = cls;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [11:0] pick_key();
        int p;
        p = $urandom_range(99);
        if (p < 5) return 12'hFFF;
        if (p < 10) return 12'($urandom_range(4095));
        if (p < 40 && q_keys.size() > 0) return q_keys[$urandom_range(q_keys.size() - 1)];
        return 12'($urandom_range(23));
    endfunction

    function automatic t_row row(logic [1:0] op, logic [11:0] k, logic cls, logic urg,
                                 logic chk = 0, logic st = 0, logic fd = 0,
                                 logic [11:0] pk = 0, logic [4:0] cnt = 0);
        t_row t;
        t.op = op; t.key = k; t.cls = cls; t.urg = urg; t.chk = chk;
        t.res.status = st; t.res.found = fd; t.res.popped_key = pk; t.res.count = cnt;
        return t;
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches + row_errors <= 10)
                    $display("unexpected result %h", o_m_tdata);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_m_tdata[18:0] != exp_r || o_m_tdata[23:19] != 0) begin
                    mismatches++;
                    if (mismatches + row_errors <= 10)
                        $display("result mismatch: expected %h, got %h", exp_r, o_m_tdata);
                end
            end
        end
    end

    always @(negedge i_clk) i_m_tready <= !idle_now();

    // Watchdog on input and result handshakes, config writes and reset.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n ||
            i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) timed_out <= 1'b1;
    end

    initial begin
        int p;
        logic [1:0] op;
        row_errors = 0; quiet_phase = 0; send_done = 0;
        q_class = 0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_wdata = 0; i_s_tvalid = 0;
        i_s_tdata = '0; i_s_tuser = tcpkq_pkg::OP_ADD;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        rows.push_back(row(tcpkq_pkg::OP_POP, 0, 0, 0, 1, 1, 0, 0, 0));
        rows.push_back(row(tcpkq_pkg::OP_LOOKUP, 12'hFFF, 0, 0, 1, 0, 0, 0, 0));
        rows.push_back(row(tcpkq_pkg::OP_REMOVE, 5, 0, 0, 1, 1, 0, 0, 0));
        rows.push_back(row(tcpkq_pkg::OP_ADD, 7, 1, 0, 1, 1, 0, 0, 0));
        rows.push_back(row(tcpkq_pkg::OP_ADD, 12'hFFF, 0, 0, 1, 0, 0, 0, 1));
        rows.push_back(row(tcpkq_pkg::OP_ADD, 0, 0, 1, 1, 0, 0, 0, 2));
        rows.push_back(row(tcpkq_pkg::OP_ADD, 0, 0, 0, 1, 1, 0, 0, 2));
        rows.push_back(row(tcpkq_pkg::OP_ADD, 9, 0, 1));
        rows.push_back(row(tcpkq_pkg::OP_ADD, 3, 0, 0));
        rows.push_back(row(tcpkq_pkg::OP_LOOKUP, 9, 0, 0, 1, 0, 1, 0, 4));
        rows.push_back(row(tcpkq_pkg::OP_REMOVE, 9, 0, 0, 1, 0, 0, 0, 3));
        rows.push_back(row(tcpkq_pkg::OP_POP, 0, 0, 0, 1, 0, 0, 0, 2));
        rows.push_back(row(tcpkq_pkg::OP_POP, 0, 0, 0, 1, 0, 0, 12'hFFF, 1));
        for (int i = 0; i < 13; i++)
            rows.push_back(row(tcpkq_pkg::OP_ADD, 12'(100 + i), 0, i[0]));
        rows.push_back(row(tcpkq_pkg::OP_ADD, 200, 1, 0, 1, 1, 0, 0, 14));
        rows.push_back(row(tcpkq_pkg::OP_ADD, 201, 0, 1, 1, 0, 0, 0, 15));
        foreach (rows[i])
            send_op(rows[i].op, rows[i].key, rows[i].cls, rows[i].urg, rows[i].chk,
                    rows[i].res);

        // Full queue, then pause until everything has been answered.
        send_op(tcpkq_pkg::OP_ADD, 202, 0, 0, 1, '{5'd16, 12'd0, 1'b0, 1'b0});
        send_op(tcpkq_pkg::OP_ADD, 203, 0, 1, 1, '{5'd16, 12'd0, 1'b0, 1'b1});
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        drain_and_config(1'b1);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 400) drain_and_config(1'b0);
            if (n == 900) drain_and_config(1'b1);
            if (n == 1300) drain_and_config(1'($urandom_range(1)));
            quiet_phase = (n >= 600 && n < 800);
            p = $urandom_range(99);
            // Lean toward adds while the queue is short, removes while it is long.
            if (p < (q_keys.size() < 8 ? 50 : 25)) op = tcpkq_pkg::OP_ADD;
            else if (p < 65) op = tcpkq_pkg::OP_REMOVE;
            else if (p < 82) op = tcpkq_pkg::OP_POP;
            else op = tcpkq_pkg::OP_LOOKUP;
            send_op(op, pick_key(), ($urandom_range(9) == 0) ? !q_class : q_class,
                    1'($urandom_range(1)), 0, '0);
        end
        i_s_tvalid <= 1'b0;
        quiet_phase = 0;
        send_done = 1;
    end

    initial begin
        wait (send_done || timed_out);
        while (pending_results.size() != 0 && !timed_out) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (timed_out) begin
            $display("CHECK FAILED");
        end else if (mismatches == 0 && row_errors == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/tcpkq_pkg.sv
hw/rtl/tcpkq_ram.sv
hw/rtl/two_class_priority_key_queue.sv
tb/sv/two_class_priority_key_queue_tb.sv
